// ===== rtl/core/ppr_pkg.sv =====
// Shared types and constants for the packed position record decoder.
// Used by the front end, the result queue, the back end and the checker.
package ppr_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PIECE = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERR   = 2'd2,
        KIND_TRUNC = 2'd3
    } kind_t;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [5:0]  square;
        logic        color;
        logic [2:0]  piece_type;
        logic [4:0]  piece_index;
        logic [5:0]  piece_count;
        logic        turn;
        logic [3:0]  castling;
        logic [3:0]  ep_file;
        logic [15:0] eval_cp;
        logic        last_of_run;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        logic two;
        res_t first;
        res_t second;
    } bundle_t;

    // queue between front and back end
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 2 ** FIFO_AW;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== rtl/core/packed_position_record_decoder.sv =====
// Packed position record decoder: byte stream in, piece and record results out.
// A result reaches m_ through the result queue and then the output register.
// Throughput: one byte per cycle while s_ready is high; two results leave in turn.
// The four-entry result queue absorbs short output stalls before s_ready drops.
// Reset: aresetn synchronous active low, clears parse state, halt flag and queue.
// Depends on ppr_pkg, ppr_front, ppr_fifo and ppr_back.
module packed_position_record_decoder
    import ppr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_stream_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [5:0]         m_square,
    output logic               m_color,
    output logic [2:0]         m_piece_type,
    output logic [4:0]         m_piece_index,
    output logic [5:0]         m_piece_count,
    output logic               m_turn,
    output logic [3:0]         m_castling,
    output logic [3:0]         m_ep_file,
    output logic signed [15:0] m_eval_cp,
    output logic               m_last_of_run
);

    logic    fifo_full;
    logic    fifo_empty;
    logic    push;
    logic    pop;
    bundle_t push_data;
    bundle_t pop_data;
    res_t    res;

    // parser front end
    ppr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_stream_end (s_stream_end),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_data    (push_data)
    );

    // result queue
    ppr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    // output back end
    ppr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (fifo_empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (res)
    );

    // result fields
    assign m_kind         = res.kind;
    assign m_square       = res.square;
    assign m_color        = res.color;
    assign m_piece_type   = res.piece_type;
    assign m_piece_index  = res.piece_index;
    assign m_piece_count  = res.piece_count;
    assign m_turn         = res.turn;
    assign m_castling     = res.castling;
    assign m_ep_file      = res.ep_file;
    assign m_eval_cp      = $signed(res.eval_cp);
    assign m_last_of_run  = res.last_of_run;

endmodule

// ===== rtl/core/ppr_front.sv =====
// Front end: bit accumulator and record parser; one byte per cycle if s_ready.
// Depends on ppr_pkg; pushes one bundle per byte that yields results.
module ppr_front
    import ppr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_stream_end,
    input  logic       fifo_full,
    output logic       push,
    output bundle_t    push_data
);

    typedef enum logic [2:0] {
        PH_COUNT  = 3'd0,
        PH_PIECE  = 3'd1,
        PH_SIDE   = 3'd2,
        PH_CASTLE = 3'd3,
        PH_EP     = 3'd4,
        PH_EVAL   = 3'd5
    } phase_t;

    function automatic logic [4:0] need_of(input phase_t ph);
        logic [4:0] n;
        case (ph)
            PH_COUNT:  n = 5'd5;
            PH_PIECE:  n = 5'd10;
            PH_SIDE:   n = 5'd1;
            PH_CASTLE: n = 5'd4;
            PH_EP:     n = 5'd4;
            PH_EVAL:   n = 5'd16;
            default:   n = 5'd5;
        endcase
        return n;
    endfunction

    // parse state
    logic [23:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    phase_t      ph_reg, ph_next;
    logic [5:0]  tot_reg, tot_next;
    logic [5:0]  done_reg, done_next;
    logic        side_reg, side_next;
    logic [3:0]  cast_reg, cast_next;
    logic [3:0]  ep_reg, ep_next;
    logic        halt_reg, halt_next;

    logic        accept;
    logic        stop;
    logic [1:0]  nres;
    res_t        r0, r1, em;
    logic        do_emit;
    logic [4:0]  need;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    // field extraction over the bits held after this byte
    always_comb begin
        acc_next  = acc_reg | ({16'd0, s_data_byte} << cnt_reg[3:0]);
        cnt_next  = cnt_reg + 5'd8;
        ph_next   = ph_reg;
        tot_next  = tot_reg;
        done_next = done_reg;
        side_next = side_reg;
        cast_next = cast_reg;
        ep_next   = ep_reg;
        halt_next = halt_reg;
        stop      = 1'b0;
        nres      = 2'd0;
        r0        = '0;
        r1        = '0;
        em        = '0;
        do_emit   = 1'b0;
        need      = 5'd0;

        // at most four fields complete per byte
        for (int i = 0; i < 4; i++) begin
            do_emit = 1'b0;
            em      = '0;
            need    = need_of(ph_next);
            if (!stop && cnt_next >= need) begin
                case (ph_next)
                    PH_COUNT: begin
                        tot_next  = {1'b0, acc_next[4:0]} + 6'd1;
                        done_next = 6'd0;
                        ph_next   = PH_PIECE;
                        acc_next  = acc_next >> 5;
                        cnt_next  = cnt_next - 5'd5;
                    end
                    PH_PIECE: begin
                        em.square      = acc_next[5:0];
                        em.color       = acc_next[6];
                        em.piece_index = done_next[4:0];
                        em.piece_count = tot_next;
                        do_emit        = 1'b1;
                        if (acc_next[9:7] == 3'd0) begin
                            em.kind   = KIND_ERR;
                            halt_next = 1'b1;
                            stop      = 1'b1;
                        end else begin
                            em.kind       = KIND_PIECE;
                            em.piece_type = acc_next[9:7];
                            done_next     = done_next + 6'd1;
                            if (done_next >= tot_next) begin
                                ph_next = PH_SIDE;
                            end
                        end
                        acc_next = acc_next >> 10;
                        cnt_next = cnt_next - 5'd10;
                    end
                    PH_SIDE: begin
                        side_next = acc_next[0];
                        ph_next   = PH_CASTLE;
                        acc_next  = acc_next >> 1;
                        cnt_next  = cnt_next - 5'd1;
                    end
                    PH_CASTLE: begin
                        cast_next = acc_next[3:0];
                        ph_next   = PH_EP;
                        acc_next  = acc_next >> 4;
                        cnt_next  = cnt_next - 5'd4;
                    end
                    PH_EP: begin
                        ep_next  = acc_next[3:0];
                        ph_next  = PH_EVAL;
                        acc_next = acc_next >> 4;
                        cnt_next = cnt_next - 5'd4;
                    end
                    default: begin
                        // record end, leftover bits of the byte dropped
                        em.kind         = KIND_END;
                        em.piece_count  = tot_next;
                        em.turn         = side_next;
                        em.castling     = cast_next;
                        em.ep_file      = ep_next;
                        em.eval_cp      = acc_next[15:0];
                        do_emit         = 1'b1;
                        acc_next        = '0;
                        cnt_next        = '0;
                        ph_next         = PH_COUNT;
                        tot_next        = '0;
                        done_next       = '0;
                        side_next       = 1'b0;
                        cast_next       = '0;
                        ep_next         = '0;
                        stop            = 1'b1;
                    end
                endcase
                if (do_emit) begin
                    if (nres == 2'd0) begin
                        r0 = em;
                    end else if (nres == 2'd1) begin
                        r1 = em;
                    end
                    if (nres != 2'd2) begin
                        nres = nres + 2'd1;
                    end
                end
            end
        end

        // end of stream inside a record
        if (s_stream_end && !halt_next) begin
            if (ph_next != PH_COUNT || cnt_next != 5'd0) begin
                em             = '0;
                em.kind        = KIND_TRUNC;
                em.piece_index = done_next[4:0];
                em.piece_count = (ph_next == PH_COUNT) ? 6'd0 : tot_next;
                if (nres == 2'd0) begin
                    r0 = em;
                end else if (nres == 2'd1) begin
                    r1 = em;
                end
                if (nres != 2'd2) begin
                    nres = nres + 2'd1;
                end
            end
            acc_next  = '0;
            cnt_next  = '0;
            ph_next   = PH_COUNT;
            tot_next  = '0;
            done_next = '0;
            side_next = 1'b0;
            cast_next = '0;
            ep_next   = '0;
        end

        // mark the last result of this byte
        if (nres == 2'd1) begin
            r0.last_of_run = 1'b1;
        end
        if (nres == 2'd2) begin
            r1.last_of_run = 1'b1;
        end
    end

    assign push      = accept && !halt_reg && (nres != 2'd0);
    assign push_data = {(nres == 2'd2), r0, r1};

    // parse state update on each transfer while not halted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            ph_reg   <= PH_COUNT;
            tot_reg  <= '0;
            done_reg <= '0;
            side_reg <= 1'b0;
            cast_reg <= '0;
            ep_reg   <= '0;
            halt_reg <= 1'b0;
        end else if (accept && !halt_reg) begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            ph_reg   <= ph_next;
            tot_reg  <= tot_next;
            done_reg <= done_next;
            side_reg <= side_next;
            cast_reg <= cast_next;
            ep_reg   <= ep_next;
            halt_reg <= halt_next;
        end
    end

endmodule

// ===== rtl/core/ppr_fifo.sv =====
// Small result queue between the parser front end and the output back end.
// Depends on ppr_pkg for the bundle type and queue depth.
module ppr_fifo
    import ppr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t pop_data,
    output logic    empty
);

    bundle_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + FIFO_CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - FIFO_CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/ppr_back.sv =====
// Back end: splits each queued bundle into single results on the m_ channel.
// Depends on ppr_pkg; holds an output register and one pending result.
module ppr_back
    import ppr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    empty,
    input  bundle_t pop_data,
    output logic    pop,
    output logic    m_valid,
    input  logic    m_ready,
    output res_t    m_res
);

    logic out_valid_reg;
    res_t out_reg;
    logic pend_valid_reg;
    res_t pend_reg;
    logic load_ok;

    assign load_ok = !out_valid_reg || m_ready;
    assign pop     = load_ok && !pend_valid_reg && !empty;
    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

    // output register and second-result holding slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (load_ok) begin
            if (pend_valid_reg) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (!empty) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= pop_data.two;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load_ok) begin
            if (pend_valid_reg) begin
                out_reg <= pend_reg;
            end else if (!empty) begin
                out_reg  <= pop_data.first;
                pend_reg <= pop_data.second;
            end
        end
    end

endmodule

// ===== rtl/core/ppr_checker.sv =====
// Port-level checker for the packed position record decoder, bound to the top.
// Depends on ppr_pkg for the result kind codes.
module ppr_checker
    import ppr_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_kind,
    input logic [5:0]         m_square,
    input logic [2:0]         m_piece_type,
    input logic [4:0]         m_piece_index,
    input logic [5:0]         m_piece_count,
    input logic signed [15:0] m_eval_cp,
    input logic               m_last_of_run
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_kind, m_square, m_piece_type,
            m_piece_index, m_piece_count, m_eval_cp, m_last_of_run}))
        else $error("result changed while stalled");

    // a piece result never carries the empty type
    a_piece_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_PIECE |-> m_piece_type != 3'd0)
        else $error("piece result with empty type");

    // an error result closes its byte's results
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERR |-> m_piece_type == 3'd0 && m_last_of_run)
        else $error("bad error result");

    // record end carries a real piece count and no piece data
    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_END |->
            m_piece_count != 6'd0 && m_square == 6'd0 && m_piece_index == 5'd0)
        else $error("bad record end result");

endmodule

bind packed_position_record_decoder ppr_checker u_ppr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_square      (m_square),
    .m_piece_type  (m_piece_type),
    .m_piece_index (m_piece_index),
    .m_piece_count (m_piece_count),
    .m_eval_cp     (m_eval_cp),
    .m_last_of_run (m_last_of_run)
);
